// File: rtl/rmsd_pkg.sv
// ============================================================================
// rmsd_pkg: shared constants and types for the running mean / std-dev core
// Widths of state, divider operations and the divider request/response structs.
// ============================================================================
`default_nettype none
package rmsd_pkg;
  localparam int FracBits   = 16;
  localparam int CountWidth = 32;
  localparam int SumWidth   = 64;

  // divider operations
  typedef enum logic [1:0] {
    OP_DIV32 = 2'b01,
    OP_DIV64 = 2'b10
  } unit_op_e;

  typedef struct packed {
    logic                start;
    unit_op_e            op;
    logic [SumWidth-1:0] dividend;
    logic [CountWidth:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SumWidth-1:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/rmsd_div.sv
// ============================================================================
// rmsd_div: shared iterative unsigned divider
// Restoring division, one quotient bit per cycle (32 or 64 steps).
// ============================================================================
`default_nettype none
module rmsd_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rmsd_pkg::div_req_t req_i,
  output rmsd_pkg::div_rsp_t     rsp_o
);
  localparam int W = rmsd_pkg::SumWidth;
  localparam int DW = rmsd_pkg::CountWidth + 1;

  logic          busy_q, busy_d;
  logic [6:0]    cnt_q, cnt_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic          done_q, done_d;
  logic [DW:0]   shl;
  logic [DW:0]   dif;

  // command load, or one restoring step while busy
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    shl    = {rem_q[DW-1:0], quo_q[W-1]};
    dif    = shl - {1'b0, dvs_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      if (req_i.op == rmsd_pkg::OP_DIV32) begin
        quo_d = {req_i.dividend[31:0], 32'd0};
        cnt_d = 7'd32;
      end else begin
        quo_d = req_i.dividend;
        cnt_d = 7'd64;
      end
    end else if (busy_q) begin
      if (!dif[DW]) begin
        rem_d = dif;
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shl;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
endmodule
`default_nettype wire

// File: rtl/rmsd_sqrt.sv
// ============================================================================
// rmsd_sqrt: iterative 64-bit integer square root
// Digit-by-digit method, one result bit per cycle.
// ============================================================================
`default_nettype none
module rmsd_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] value_i,
  output logic             done_o,
  output logic [31:0]      root_o
);
  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [63:0] v_q;
  logic [63:0] root_q;
  logic [63:0] bit_q;
  logic [63:0] trial;
  logic        done_q;

  assign trial = root_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // bit starts at 2^62 and moves down two places a step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= value_i;
      root_q <= '0;
      bit_q  <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q    <= v_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[31:0];
endmodule
`default_nettype wire

// File: rtl/running_mean_std_dev_core.sv
// ============================================================================
// running_mean_std_dev_core: Welford running mean and standard deviation
// Sequencer around a shared serial divider, a 32x32 multiplier and a sqrt unit.
// ============================================================================
// Sequence: an accepted request runs the 32-step mean division, the multiply,
//   the 64-step sum/count division and the 32-step square root, then loads the
//   result register; when the count is full only the sigma path runs.
// s_axis_tready is high only while idle, so a new request is taken only once the
//   last one is done. A waiting result stalls only the end of the next request.
// Reset: asynchronous active low; count, mean and sum clear to zero.
`default_nettype none
module running_mean_std_dev_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [31:0] sample
  input  wire logic        s_axis_tuser,  // [0] restart
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,  // [31:0] count, [63:32] mean_value, [95:64] std_dev
  output logic             m_axis_tuser   // [0] saturated
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV1  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_ACC   = 7'b0001000,
    S_DIV2  = 7'b0010000,
    S_SQRT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  localparam logic [rmsd_pkg::CountWidth-1:0] CountMax = '1;

  state_e         state_q, state_d;
  logic [31:0]    cnt_q;
  logic [31:0]    mean_q;
  logic [63:0]    sum_q;
  logic [32:0]    mag_q;
  logic           neg_q;
  logic [32:0]    qm_q;
  logic [63:0]    prod_q;
  logic           sat_q;
  logic           ovalid_q;
  logic [95:0]    odata_q;
  logic           ouser_q;
  logic           wait_q;

  rmsd_pkg::div_req_t dreq;
  rmsd_pkg::div_rsp_t drsp;
  logic               sq_start;
  logic               sq_done;
  logic [31:0]        sq_root;
  logic [32:0]        delta;
  logic [64:0]        sum_add;
  logic [63:0]        sum_new;
  logic [31:0]        cnt_in;
  logic [31:0]        mean_in;
  logic [63:0]        sum_in;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic               out_free;

  rmsd_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));
  rmsd_sqrt u_sqrt (.clk_i, .rst_ni, .start_i(sq_start), .value_i(drsp.quot),
                    .done_o(sq_done), .root_o(sq_root));

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free = !ovalid_q || m_axis_tready;
  assign cnt_in  = s_axis_tuser ? 32'd0 : cnt_q;
  assign mean_in = s_axis_tuser ? 32'd0 : mean_q;
  assign sum_in  = s_axis_tuser ? 64'd0 : sum_q;
  assign delta   = {s_axis_tdata[31], s_axis_tdata} - {mean_in[31], mean_in};
  assign sum_add = {1'b0, sum_q} + {1'b0, prod_q};
  // saturating sum after this sample, held when the count is full
  assign sum_new = sat_q ? sum_q : (sum_add[64] ? '1 : sum_add[63:0]);

  // |delta| times (|delta| - |step|), both fit 32 bits
  assign mul_a = mag_q[31:0];
  assign mul_b = mag_q[31:0] - qm_q[31:0];
  assign mul_p = mul_a * mul_b;

  // unit commands
  always_comb begin
    dreq       = '0;
    dreq.op    = rmsd_pkg::OP_DIV32;
    sq_start   = 1'b0;
    if (state_q == S_IDLE && s_axis_tvalid && s_axis_tready && cnt_in != CountMax) begin
      dreq.start    = 1'b1;
      dreq.dividend = {31'd0, delta[32] ? -delta : delta};
      dreq.divisor  = {1'b0, cnt_in} + 33'd1;
    end else if (state_q == S_ACC) begin
      dreq.start    = 1'b1;
      dreq.op       = rmsd_pkg::OP_DIV64;
      dreq.dividend = sum_new;
      dreq.divisor  = {1'b0, cnt_q};
    end
    if (state_q == S_DIV2 && drsp.done && !wait_q) sq_start = 1'b1;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid && s_axis_tready)
                state_d = (cnt_in != CountMax) ? S_DIV1 : S_ACC;
      S_DIV1: if (drsp.done) state_d = S_MUL;
      S_MUL:  state_d = S_ACC;
      S_ACC:  state_d = S_DIV2;
      S_DIV2: if (drsp.done) state_d = S_SQRT;
      S_SQRT: if (sq_done) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      mean_q   <= '0;
      sum_q    <= '0;
      ovalid_q <= 1'b0;
      sat_q    <= 1'b0;
      wait_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= 1'b0;
      // result register: load when free, clear when taken
      if (state_q == S_OUT && out_free) ovalid_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          cnt_q  <= cnt_in;
          mean_q <= mean_in;
          sum_q  <= sum_in;
          sat_q  <= (cnt_in == CountMax);
        end
        S_MUL: begin
          cnt_q  <= cnt_q + 32'd1;
          mean_q <= neg_q ? mean_q - qm_q[31:0] : mean_q + qm_q[31:0];
        end
        S_ACC: sum_q <= sum_new;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid && s_axis_tready) begin
      neg_q <= delta[32];
      mag_q <= delta[32] ? -delta : delta;
    end
    if (state_q == S_DIV1 && drsp.done) qm_q <= drsp.quot[32:0];
    if (state_q == S_MUL) prod_q <= mul_p;
    if (state_q == S_IDLE) prod_q <= '0;
    if (state_q == S_OUT && out_free) begin
      odata_q <= {sq_root, mean_q, cnt_q};
      ouser_q <= sat_q || (sum_q == '1);
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
endmodule
`default_nettype wire

// File: rtl/rmsd_checker.sv
// ============================================================================
// rmsd_checker: port-level checks for the running mean / std-dev core
// Watches handshakes and result ordering on the top-level ports.
// ============================================================================
`default_nettype none
module rmsd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [95:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  // core goes busy after taking a request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("accept while busy");
  // a request is never answered in the next cycle
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("early result");
  // result held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result dropped");
  // count never reported as zero unless saturated
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:0] != 32'd0)
    else $error("zero count");
endmodule

bind running_mean_std_dev_core rmsd_checker u_rmsd_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
`default_nettype wire

// File: test/running_mean_std_dev_core_tb.sv
// ============================================================================
// running_mean_std_dev_core_tb: self-checking bench for the Welford core
// Drives samples with random restarts and gaps, predicts count, mean, sigma
// and the saturation flag per request, and compares each response in order.
// ============================================================================
`default_nettype none
module running_mean_std_dev_core_tb;

  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] mean_value;
    logic [31:0] std_dev;
    logic        saturated;
  } welford_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;

  running_mean_std_dev_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // predictor state
  logic [rmsd_pkg::CountWidth-1:0] acc_count;
  logic signed [31:0]              acc_mean;
  logic [rmsd_pkg::SumWidth-1:0]   acc_sum;

  welford_result_t expected_results[$];
  int  mismatch_count;
  int  response_count;
  int  restart_count;
  int  sat_count;
  bit  idle_enable;
  bit  hold_sink;
  int  idle_cycles;
  bit  timed_out;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] sqrt_floor(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Welford update for one accepted request
  function automatic welford_result_t welford_update(logic [31:0] sample, logic restart);
    welford_result_t r;
    logic [32:0]         n;
    logic signed [33:0]  delta;
    logic [33:0]         mag;
    logic [33:0]         qm;
    logic [63:0]         prod;
    logic [63:0]         sigma;
    logic [rmsd_pkg::CountWidth:0] full_count;
    logic                sat;
    sat = 1'b0;
    full_count = {1'b0, {rmsd_pkg::CountWidth{1'b1}}};
    if (restart) begin
      acc_count = '0;
      acc_mean  = '0;
      acc_sum   = '0;
    end
    if ({1'b0, acc_count} >= full_count) begin
      sat = 1'b1;
    end else begin
      n     = {1'b0, acc_count} + 33'd1;
      delta = $signed({{2{sample[31]}}, sample}) - $signed({{2{acc_mean[31]}}, acc_mean});
      mag   = delta[33] ? -delta : delta;
      qm    = mag / n;
      prod  = 64'(mag) * 64'(mag - qm);
      acc_count = n[rmsd_pkg::CountWidth-1:0];
      if (prod > ~acc_sum) acc_sum = '1;
      else acc_sum = acc_sum + prod;
      acc_mean = delta[33] ? acc_mean - qm[31:0] : acc_mean + qm[31:0];
    end
    if (acc_sum == '1) sat = 1'b1;
    sigma = (acc_count != 0) ? sqrt_floor(acc_sum / 64'(acc_count)) : '0;
    r.count      = acc_count;
    r.mean_value = acc_mean;
    r.std_dev    = sigma[31:0];
    r.saturated  = sat;
    return r;
  endfunction

  // send one request, predicting on acceptance
  task automatic send_sample(logic [31:0] sample, logic restart);
    while (idle_enable && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    s_axis_tuser  <= restart;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(welford_update(sample, restart));
    if (restart) restart_count++;
  endtask

  // receiver with random stalls and a forced long hold-off
  always @(posedge clk_i) begin
    if (hold_sink) m_axis_tready <= 1'b0;
    else m_axis_tready <= !(idle_enable && $urandom_range(99) < 32);
  end

  // response checker
  always @(posedge clk_i) begin
    welford_result_t got;
    welford_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.count      = m_axis_tdata[31:0];
      got.mean_value = m_axis_tdata[63:32];
      got.std_dev    = m_axis_tdata[95:64];
      got.saturated  = m_axis_tuser;
      response_count++;
      if (got.saturated) sat_count++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected response count=%0d", got.count);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp cnt=%0d mean=%h sd=%h sat=%b got cnt=%0d mean=%h sd=%h sat=%b",
                     exp_r.count, exp_r.mean_value, exp_r.std_dev, exp_r.saturated,
                     got.count, got.mean_value, got.std_dev, got.saturated);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // extremes, restart and sign cases
  task automatic test_directed();
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0001_0000, 1'b1);
    send_sample(32'h0003_0000, 1'b0);
    send_sample(32'hFFFE_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h5555_5555, 1'b0);
    send_sample(32'hAAAA_AAAA, 1'b0);
    send_sample(32'h0000_0001, 1'b1);
  endtask

  // random runs of varying length, mixed value spreads
  task automatic test_random(int n_items);
    logic [31:0] s;
    int k;
    for (int i = 0; i < n_items; i++) begin
      k = $urandom_range(9);
      if (k < 4) s = $urandom();
      else if (k < 8) s = $signed($urandom_range(262143)) - 131072;
      else s = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(15) : 32'h8000_0000 + $urandom_range(15);
      send_sample(s, $urandom_range(39) == 0);
    end
  endtask

  // receiver blocked while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_sample($urandom(), 1'b0);
    join
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    acc_count = '0;
    acc_mean = '0;
    acc_sum = '0;
    mismatch_count = 0;
    response_count = 0;
    restart_count = 0;
    sat_count = 0;
    idle_enable = 1'b1;
    hold_sink = 1'b0;
    idle_cycles = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    idle_enable = 1'b0;
    test_random(300);
    idle_enable = 1'b1;
    test_random(1430);
    s_axis_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d responses, %0d restarts, %0d saturated flags.",
             response_count, restart_count, sat_count);
    $display("Included extreme samples, random stalls on both sides and a long receiver hold-off.");
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
